### rtl/core/cfa_pkg.sv
`default_nettype none
package cfa_pkg;

  localparam int NodeAw = 12;
  localparam int NodeDepth = 4096;
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_XPART = 2'd1;
  localparam logic [1:0] CMD_YPART = 2'd2;
  localparam logic [1:0] SOIL_A = 2'd1;
  localparam logic [1:0] SOIL_B = 2'd2;
  localparam logic [1:0] REG_COND_A = 2'd0;
  localparam logic [1:0] REG_COND_B = 2'd1;
  localparam logic [1:0] REG_UNIT_AXIS = 2'd2;
  localparam logic [1:0] REG_CELL_SIZE = 2'd3;
  localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

  // shared multiplier request
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  // divider control
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  function automatic logic signed [63:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 64'sd2147483647;
    if (x < -66'sd2147483648) return -64'sd2147483648;
    return x[63:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/cell_flux_average_core.sv
`default_nettype none
// Cell flux averaging core. A node load (cmd 0) is written on acceptance; an
// element x part (cmd 1) and a y part (cmd 2) read three nodes each, and a y
// part with a known soil code goes on through KX, KY, AX, AY and OUT. Every
// node-store read goes through the single memory port and every product
// through one shared 33x33 multiplier. A y part marked last adds an 80-step
// restoring divide per flux component and then hands the pair to the result
// register. The block is not ready while it works on an item; the result
// register holds until taken and the next request is accepted meanwhile, and a
// second result waits in the sequencer until the register is free.
module cell_flux_average_core
  import cfa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: cmd[1:0], index_a, index_b, index_c, coef_a, coef_b, coef_c,
  // soil_code, elem_area, zero fill (176 bits)
  input  wire logic [175:0] in_tdata,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: flux_x, flux_y
  output logic [63:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [30:0]  cfg_wdata
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_MUL = 4'd2, S_ACC = 4'd3,
    S_GRAD = 4'd4, S_KX = 4'd5, S_KY = 4'd6, S_AX = 4'd7, S_AY = 4'd8,
    S_DIVX = 4'd9, S_DIVY = 4'd10, S_OUT = 4'd11, S_WAITX = 4'd12,
    S_WAITY = 4'd13, S_HOLD = 4'd14;

  logic [30:0] cond_a_r, cond_b_r, cell_size_r;
  logic        unit_axis_r;
  logic [3:0]  st_r, st_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [1:0]  cmd_r;
  logic [31:0] coef_r [3];
  logic [1:0]  soil_r;
  logic [30:0] area_r;
  logic        last_r;
  logic [35:0] corners_r;
  logic signed [63:0] grad_x_r, acc_r, qx_r, qy_r, gy_r;
  logic signed [63:0] sum_x_r, sum_y_r;
  logic [31:0] mem [NodeDepth];
  logic [31:0] rd_r;
  logic [NodeAw-1:0] rd_addr;
  logic [31:0] fx_r;
  logic        outv_r;
  logic [63:0] out_r;
  mul_req_t    mreq;
  logic signed [63:0] mp;
  div_req_t    dreq;
  logic        ddone;
  logic [79:0] dq;
  logic        neg_r;

  cfa_mul u_mul (.clk(clk), .req(mreq), .prod_floor(mp));
  cfa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = outv_r;
  assign out_tdata = out_r;

  // node memory, one port
  always_comb begin
    case (k_r)
      2'd0: rd_addr = corners_r[11:0];
      2'd1: rd_addr = corners_r[23:12];
      default: rd_addr = corners_r[35:24];
    endcase
  end
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && in_tdata[1:0] == CMD_LOAD) begin
      mem[in_tdata[13:2]] <= in_tdata[69:38];
    end
    rd_r <= mem[rd_addr];
  end

  // saturating 64-bit add
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  logic signed [63:0] gsel, kqsel;
  logic [63:0] mag;
  logic [79:0] qfin;
  logic [31:0] fres;
  always_comb begin
    gsel = gy_r;
    kqsel = (unit_axis_r == 1'b0) ? grad_x_r + ONE_Q16 : grad_x_r;
    mreq.a = 33'sd0;
    mreq.b = 33'sd0;
    case (st_r)
      S_MUL: begin
        mreq.a = {rd_r[31], rd_r};
        mreq.b = {coef_r[k_r][31], coef_r[k_r]};
      end
      S_KX: begin
        mreq.a = {2'b00, (soil_r == SOIL_A) ? cond_a_r : cond_b_r};
        mreq.b = kqsel[32:0];
      end
      S_KY: begin
        mreq.a = {2'b00, (soil_r == SOIL_A) ? cond_a_r : cond_b_r};
        gsel = (unit_axis_r == 1'b1) ? gy_r + ONE_Q16 : gy_r;
        mreq.b = gsel[32:0];
      end
      S_AX: begin
        mreq.a = qx_r[32:0];
        mreq.b = {2'b00, area_r};
      end
      S_AY: begin
        mreq.a = qy_r[32:0];
        mreq.b = {2'b00, area_r};
      end
      default: ;
    endcase
    mag = (st_r == S_DIVY) ? (sum_y_r[63] ? 64'd0 - sum_y_r : sum_y_r)
                           : (sum_x_r[63] ? 64'd0 - sum_x_r : sum_x_r);
    dreq.start = (st_r == S_DIVX) || (st_r == S_DIVY);
    dreq.dividend = mag;
    dreq.divisor = cell_size_r;
    qfin = (dq[79:48] != '0) ? 80'hFFFFFFFFFFFF : dq;
    if (!neg_r) fres = (qfin > 80'd2147483647) ? 32'h7FFFFFFF : qfin[31:0];
    else fres = (qfin > 80'd2147483648) ? 32'h80000000 : 32'd0 - qfin[31:0];
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    k_nxt = k_r;
    case (st_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        k_nxt = 2'd0;
        if (in_tdata[1:0] == CMD_XPART || in_tdata[1:0] == CMD_YPART) st_nxt = S_RD;
      end
      S_RD: st_nxt = S_MUL;
      S_MUL: st_nxt = S_ACC;
      S_ACC: begin
        if (k_r == 2'd2) st_nxt = S_GRAD;
        else begin
          k_nxt = k_r + 2'd1;
          st_nxt = S_RD;
        end
      end
      S_GRAD: begin
        if (cmd_r == CMD_XPART) st_nxt = S_IDLE;
        else if (soil_r == SOIL_A || soil_r == SOIL_B) st_nxt = S_KX;
        else st_nxt = last_r ? S_DIVX : S_IDLE;
      end
      S_KX: st_nxt = S_KY;
      S_KY: st_nxt = S_AX;
      S_AX: st_nxt = S_AY;
      S_AY: st_nxt = S_OUT;
      S_OUT: st_nxt = last_r ? S_DIVX : S_IDLE;
      S_DIVX: st_nxt = S_WAITX;
      S_WAITX: if (ddone) st_nxt = S_DIVY;
      S_DIVY: st_nxt = S_WAITY;
      S_WAITY: if (ddone) st_nxt = S_HOLD;
      S_HOLD: if (!outv_r || out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      k_r <= '0;
      cond_a_r <= 31'd65536;
      cond_b_r <= 31'd65536;
      cell_size_r <= 31'd65536;
      unit_axis_r <= 1'b0;
      corners_r <= '0;
      grad_x_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      k_r <= k_nxt;
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_COND_A: cond_a_r <= cfg_wdata;
          REG_COND_B: cond_b_r <= cfg_wdata;
          REG_UNIT_AXIS: unit_axis_r <= cfg_wdata[0];
          REG_CELL_SIZE: cell_size_r <= cfg_wdata;
          default: ;
        endcase
      end
      // load the result register once it is free, else drop valid when taken
      if (st_r == S_HOLD && (!outv_r || out_tready)) begin
        out_r <= {fres, fx_r};
        outv_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        outv_r <= 1'b0;
      end
      // capture the request
      if (st_r == S_IDLE && in_tvalid && in_tready) begin
        cmd_r <= in_tdata[1:0];
        coef_r[0] <= in_tdata[69:38];
        coef_r[1] <= in_tdata[101:70];
        coef_r[2] <= in_tdata[133:102];
        soil_r <= in_tdata[135:134];
        area_r <= in_tdata[166:136];
        last_r <= in_tlast;
        acc_r <= '0;
        if (in_tdata[1:0] == CMD_XPART) corners_r <= in_tdata[37:2];
      end
      if (st_r == S_ACC) acc_r <= acc_r + mp;
      if (st_r == S_GRAD) begin
        if (cmd_r == CMD_XPART) grad_x_r <= sat32({{2{acc_r[63]}}, acc_r});
        else gy_r <= sat32({{2{acc_r[63]}}, acc_r});
      end
      if (st_r == S_KY) qx_r <= sat32({{2{mp[63]}}, mp});
      if (st_r == S_AX) qy_r <= sat32({{2{mp[63]}}, mp});
      if (st_r == S_AY) sum_x_r <= sadd(sum_x_r, mp);
      if (st_r == S_OUT) sum_y_r <= sadd(sum_y_r, mp);
      if (st_r == S_DIVX) neg_r <= sum_x_r[63];
      if (st_r == S_DIVY) neg_r <= sum_y_r[63];
      if (st_r == S_WAITX && ddone) fx_r <= fres;
      if (st_r == S_WAITY && ddone) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/cfa_mul.sv
`default_nettype none
module cfa_mul
  import cfa_pkg::*;
(
  input  wire logic                clk,
  input  wire mul_req_t            req,
  output logic signed [63:0]       prod_floor
);
  logic signed [65:0] prod;

  // multiply and floor the Q16.16 product, registered
  assign prod = req.a * req.b;
  always_ff @(posedge clk) begin
    prod_floor <= $signed(prod[63:0]) >>> 16;
  end
endmodule
`default_nettype wire

### rtl/core/cfa_div.sv
`default_nettype none
module cfa_div
  import cfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire div_req_t    req,
  output logic             done,
  output logic [79:0]      quot
);
  // restoring divider, one quotient bit a cycle over dividend << 16
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [79:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] trial;
  logic [30:0] den;

  assign den = (req.divisor == '0) ? 31'd1 : req.divisor;
  assign trial = {rem_r[30:0], q_r[79]};

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    done = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd0;
      q_nxt = {req.dividend, 16'd0};
      rem_nxt = '0;
    end else if (busy_r) begin
      // shift one bit in, subtract when it fits
      q_nxt = {q_r[78:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd79) begin
        busy_nxt = 1'b0;
      end
    end
    if (!busy_r && cnt_r == 7'd80) begin
      done = 1'b1;
    end
  end

  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= (done ? 7'd0 : cnt_nxt);
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end
endmodule
`default_nettype wire

### bench/flux_checker.sv
`timescale 1ns / 100ps
module flux_checker
  import cfa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [175:0] in_tdata,
  input  wire logic         in_tlast,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [63:0]  out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [30:0]  cfg_wdata,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic signed [31:0] fy;
    logic signed [31:0] fx;
  } flux_t;

  localparam longint I32MAX = 64'sd2147483647;
  localparam longint I32MIN = -64'sd2147483648;

  longint node_val [NodeDepth];
  logic [11:0] crn_a, crn_b, crn_c;
  longint grad_x_held, acc_x, acc_y;
  longint k_a, k_b, area_div;
  logic axis_y;
  flux_t flux_q[$];

  function automatic longint fl16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint clip32(longint x);
    if (x > I32MAX) return I32MAX;
    if (x < I32MIN) return I32MIN;
    return x;
  endfunction

  function automatic longint acc_add(longint a, longint b);
    longint s;
    s = a + b;
    if (b > 0 && s < a) return 64'h7fffffffffffffff;
    if (b < 0 && s > a) return 64'sh8000000000000000;
    return s;
  endfunction

  function automatic longint grad_of(longint ca, longint cb, longint cc);
    return clip32(fl16(node_val[crn_a] * ca) + fl16(node_val[crn_b] * cb) +
                  fl16(node_val[crn_c] * cc));
  endfunction

  function automatic logic signed [31:0] avg_of(longint s, longint d);
    logic neg;
    longint unsigned m, q1, r, q, du;
    neg = s < 0;
    m = neg ? -s : s;
    du = (d == 0) ? 1 : d;
    q1 = m / du;
    r = m % du;
    if (q1 >= 64'h100000000) q = 64'hFFFFFFFFFFFF;
    else q = (q1 << 16) + ((r << 16) / du);
    if (!neg) return (q > 64'd2147483647) ? 32'h7fffffff : q[31:0];
    return (q > 64'd2147483648) ? 32'h80000000 : -q[31:0];
  endfunction

  assign pending_count = flux_q.size();

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    logic [1:0] op, soil;
    longint ca, cb, cc, k, gx, gy, qx, qy;
    flux_t got, want;
    int errs;
    if (!rst_n) begin
      crn_a <= 0; crn_b <= 0; crn_c <= 0;
      grad_x_held = 0; acc_x = 0; acc_y = 0;
      k_a = 65536; k_b = 65536; axis_y = 0; area_div = 65536;
      fail_count <= 0;
      flux_q.delete();
    end else begin
      errs = 0;
      if (cfg_we) begin
        case (cfg_index)
          REG_COND_A: k_a = cfg_wdata;
          REG_COND_B: k_b = cfg_wdata;
          REG_UNIT_AXIS: axis_y = cfg_wdata[0];
          REG_CELL_SIZE: area_div = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        op = in_tdata[1:0];
        ca = longint'($signed(in_tdata[69:38]));
        cb = longint'($signed(in_tdata[101:70]));
        cc = longint'($signed(in_tdata[133:102]));
        soil = in_tdata[135:134];
        if (op == CMD_LOAD) begin
          node_val[in_tdata[13:2]] = ca;
        end else if (op == CMD_XPART) begin
          crn_a = in_tdata[13:2]; crn_b = in_tdata[25:14]; crn_c = in_tdata[37:26];
          grad_x_held = grad_of(ca, cb, cc);
        end else if (op == CMD_YPART) begin
          if (soil == SOIL_A || soil == SOIL_B) begin
            k = (soil == SOIL_A) ? k_a : k_b;
            gx = grad_x_held;
            gy = grad_of(ca, cb, cc);
            if (axis_y) gy += 65536; else gx += 65536;
            qx = clip32(fl16(k * gx));
            qy = clip32(fl16(k * gy));
            acc_x = acc_add(acc_x, fl16(qx * longint'(in_tdata[166:136])));
            acc_y = acc_add(acc_y, fl16(qy * longint'(in_tdata[166:136])));
          end
          if (in_tlast) begin
            want.fx = avg_of(acc_x, area_div);
            want.fy = avg_of(acc_y, area_div);
            flux_q.push_back(want);
            acc_x = 0; acc_y = 0;
          end
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (flux_q.size() == 0) begin
          $error("unexpected flux result %h", out_tdata);
          errs++;
        end else begin
          want = flux_q.pop_front();
          if (got.fx != want.fx) begin
            $error("flux_x expected %0d actual %0d", want.fx, got.fx);
            errs++;
          end
          if (got.fy != want.fy) begin
            $error("flux_y expected %0d actual %0d", want.fy, got.fy);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
module tb
  import cfa_pkg::*;
();

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [63:0]  out_tdata;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = REG_COND_A;
  logic [30:0]  cfg_wdata = '0;
  int           fail_count, pending_count;
  logic [11:0]  loaded_nodes[$];
  logic         calm = 0;

  always #1 clk = ~clk;

  cell_flux_average_core dut (.*);
  flux_checker chk (.*);

  // result side: stall about 18 percent of cycles unless calm is set
  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 18);

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] rand_node();
    return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
  endfunction

  // hold valid high after the handshake; the next request or a drain replaces it
  task automatic send(input logic [1:0] op, input logic [11:0] a, b, c,
                      input logic [31:0] ca, cb, cc, input logic [1:0] soil,
                      input logic [30:0] area, input logic last);
    while (!calm && $urandom_range(99) < 18) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {9'd0, area, soil, cc, cb, ca, c, b, a, op};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    if (op == CMD_LOAD) loaded_nodes.push_back(a);
  endtask

  task automatic element(input logic [1:0] soil, input logic [30:0] area,
                         input logic last);
    send(CMD_XPART, rand_node(), rand_node(), rand_node(), rand_val(), rand_val(),
         rand_val(), 2'($urandom), 31'($urandom), 1'($urandom));
    send(CMD_YPART, 12'($urandom), 12'($urandom), 12'($urandom), rand_val(), rand_val(),
         rand_val(), soil, area, last);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
  endtask

  initial begin
    #200000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [30:0] area;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extreme loads, ignored ops, odd soil codes
    send(CMD_LOAD, 12'd0, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 1);
    send(CMD_LOAD, 12'hfff, 0, 0, 32'h80000000, 0, 0, 0, 0, 0);
    send(CMD_LOAD, 12'd1, 0, 0, 32'h00010000, 0, 0, 0, 0, 0);
    send(2'd3, 12'hfff, 12'hfff, 12'hfff, '1, '1, '1, 2'd3, '1, 1);
    send(CMD_YPART, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0, SOIL_A, 31'h7fffffff, 1);
    send(CMD_XPART, 12'd0, 12'hfff, 12'd1, 32'h7fffffff, 32'h80000000, 32'hffffffff,
         0, 0, 1);
    send(CMD_YPART, 12'hfff, 0, 12'd1, 32'h80000000, 32'h7fffffff, 32'h10000,
         SOIL_B, 31'h7fffffff, 0);
    send(CMD_YPART, 0, 0, 0, 0, 0, 0, 2'd0, 31'h7fffffff, 0);
    send(CMD_YPART, 0, 0, 0, 0, 0, 0, 2'd3, 31'h10000, 1);
    element(SOIL_A, 31'h7fffffff, 1);
    drain();

    // several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_COND_A, ph == 0 ? 31'd0 : ph == 1 ? 31'h7fffffff :
                31'($urandom_range(262143)));
      write_reg(REG_COND_B, ph == 2 ? 31'd0 : ph == 3 ? 31'h7fffffff :
                31'($urandom_range(262143)));
      write_reg(REG_UNIT_AXIS, 31'(ph[0]));
      write_reg(REG_CELL_SIZE, ph == 4 ? 31'd1 : ph == 5 ? 31'h7fffffff :
                31'($urandom_range(32'h7fffffff, 1)));
      cfg_we <= 0;
      calm = (ph == 3);
      n = 0;
      while (n < 315) begin
        if ($urandom_range(9) < 2) begin
          send(CMD_LOAD, 12'($urandom), 12'($urandom), 12'($urandom), rand_val(),
               $urandom, $urandom, 2'($urandom), 31'($urandom), 1'($urandom));
          n++;
        end else if ($urandom_range(19) == 0) begin
          send($urandom_range(1) ? 2'd3 : CMD_YPART, 12'($urandom), 12'($urandom),
               12'($urandom), rand_val(), rand_val(), rand_val(), 2'($urandom),
               31'($urandom), 1'($urandom));
          n++;
        end else begin
          area = 31'($urandom_range(3) == 0 ? $urandom : $urandom_range(131072));
          element($urandom_range(7) == 0 ? 2'($urandom_range(1) * 3) :
                  2'($urandom_range(2, 1)), area, $urandom_range(3) == 0);
          n += 2;
        end
      end
      element(SOIL_A, 31'h10000, 1);
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
